// ----- rtl/status_led_blink_sequencer_defines.svh -----
// Assertion macros for the status LED blink sequencer.
// Expects clk_i and rst_ni to be visible where the macros are used.
`ifndef STATUS_LED_BLINK_SEQUENCER_DEFINES_SVH
`define STATUS_LED_BLINK_SEQUENCER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SLBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("status LED sequencer check failed");

// Consequent checked in the cycle after the antecedent.
`define SLBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("status LED sequencer check failed");

`endif

// ----- rtl/slbs_pkg.sv -----
// Shared types, codes and pattern tables for the status LED blink sequencer.
// No dependencies.
package slbs_pkg;

  localparam int unsigned TicksPerMsDef = 1;
  localparam int unsigned TicksWidth    = 11;
  localparam int unsigned TicksMax      = 2047;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MODE = 1'b1;

  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_STARTUP = 3'd1;
  localparam logic [2:0] MODE_WIFI    = 3'd2;
  localparam logic [2:0] MODE_MQTT    = 3'd3;
  localparam logic [2:0] MODE_SMART   = 3'd4;
  localparam logic [2:0] MODE_OTA     = 3'd5;
  localparam logic [2:0] MODE_READY   = 3'd6;
  localparam logic [2:0] MODE_ERROR   = 3'd7;

  typedef enum logic [2:0] {
    PER_75,
    PER_100,
    PER_150,
    PER_200,
    PER_400,
    PER_1000,
    PER_2000
  } period_e;

  // Period in milliseconds scaled to ticks, saturated to the countdown range.
  function automatic int unsigned sat_ticks(input int unsigned ms, input int unsigned tpm);
    int unsigned t;
    t = ms * tpm;
    if (t > TicksMax) begin
      t = TicksMax;
    end
    return t;
  endfunction

  // Number of phases in each blinking pattern.
  function automatic logic [3:0] pat_len(input logic [2:0] mode);
    logic [3:0] len;
    case (mode)
      MODE_WIFI:  len = 4'd2;
      MODE_MQTT:  len = 4'd4;
      MODE_SMART: len = 4'd6;
      MODE_OTA:   len = 4'd8;
      MODE_READY: len = 4'd4;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

  // Period of one phase of a blinking pattern.
  function automatic period_e pat_period(input logic [2:0] mode, input logic [2:0] ph);
    period_e p;
    p = PER_200;
    case (mode)
      MODE_WIFI:  p = (ph == 3'd1) ? PER_1000 : PER_200;
      MODE_MQTT:  p = (ph == 3'd3) ? PER_2000 : PER_400;
      MODE_SMART: p = (ph == 3'd5) ? PER_1000 : PER_200;
      MODE_OTA:   p = (ph == 3'd7) ? PER_1000 : PER_200;
      MODE_READY: begin
        case (ph)
          3'd1:    p = PER_75;
          3'd3:    p = PER_1000;
          default: p = PER_150;
        endcase
      end
      default:    p = PER_200;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/status_led_blink_sequencer.sv -----
// Status LED blink sequencer: countdown, pattern table and result register.
// Depends on slbs_pkg and status_led_blink_sequencer_defines.svh.
//
// Channel  | Direction | Handshake                     | Payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata: mode, tuser: action
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: pin_level, tuser: step_taken
// cfg      | in        | cfg_valid_i / cfg_ready_o     | cfg_data_i: active_high
//
// One beat per cycle while the result is drained; each input beat yields its result beat in the next cycle.
// The state update and table lookup sit between the input and the result register.
// A stalled result blocks input only while the result register is full and not drained.
// Reset leaves mode off, phase 0, LED unlit, countdown at 200 ms and polarity active high.
`include "status_led_blink_sequencer_defines.svh"

module status_led_blink_sequencer
  import slbs_pkg::*;
#(
  parameter int unsigned TICKS_PER_MS = TicksPerMsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [2:0] mode, [7:3] zero
  input  logic       s_axis_tuser,   // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] pin_level, [7:1] zero
  output logic       m_axis_tuser,   // [0] step_taken
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  localparam logic [TicksWidth-1:0] T75   = TicksWidth'(sat_ticks(75, TICKS_PER_MS));
  localparam logic [TicksWidth-1:0] T100  = TicksWidth'(sat_ticks(100, TICKS_PER_MS));
  localparam logic [TicksWidth-1:0] T150  = TicksWidth'(sat_ticks(150, TICKS_PER_MS));
  localparam logic [TicksWidth-1:0] T200  = TicksWidth'(sat_ticks(200, TICKS_PER_MS));
  localparam logic [TicksWidth-1:0] T400  = TicksWidth'(sat_ticks(400, TICKS_PER_MS));
  localparam logic [TicksWidth-1:0] T1000 = TicksWidth'(sat_ticks(1000, TICKS_PER_MS));
  localparam logic [TicksWidth-1:0] T2000 = TicksWidth'(sat_ticks(2000, TICKS_PER_MS));

  logic                  active_high_q;
  logic [2:0]            mode_q, mode_d;
  logic [3:0]            phase_q, phase_d;
  logic [TicksWidth-1:0] ticks_q, ticks_d;
  logic                  lit_q, lit_d;
  logic                  step_d;
  period_e               per;
  logic                  m_valid_q;
  logic                  m_pin_q;
  logic                  m_step_q;
  logic                  s_fire;
  logic [2:0]            in_mode;

  assign in_mode       = s_axis_tdata[2:0];
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    ticks_d = ticks_q;
    lit_d   = lit_q;
    step_d  = 1'b0;
    per     = PER_100;
    if (s_axis_tuser == ACT_MODE) begin
      if (in_mode != mode_q) begin
        mode_d  = in_mode;
        phase_d = 4'd0;
      end
    end else if (ticks_q > TicksWidth'(1)) begin
      ticks_d = ticks_q - TicksWidth'(1);
    end else begin
      step_d = 1'b1;
      if (mode_q == MODE_OFF) begin
        lit_d = 1'b0;
        per   = PER_1000;
      end else if (mode_q == MODE_ERROR) begin
        lit_d = 1'b1;
        per   = PER_1000;
      end else if (mode_q == MODE_STARTUP) begin
        lit_d   = !phase_q[0];
        phase_d = phase_q + 4'd1;
        per     = PER_200;
      end else if (phase_q < pat_len(mode_q)) begin
        lit_d   = !phase_q[0];
        phase_d = phase_q + 4'd1;
        per     = pat_period(mode_q, phase_q[2:0]);
      end else begin
        phase_d = 4'd0;
        per     = PER_100;
      end
      unique case (per)
        PER_75:   ticks_d = T75;
        PER_100:  ticks_d = T100;
        PER_150:  ticks_d = T150;
        PER_200:  ticks_d = T200;
        PER_400:  ticks_d = T400;
        PER_1000: ticks_d = T1000;
        PER_2000: ticks_d = T2000;
        default:  ticks_d = T100;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_high_q <= 1'b1;
      mode_q        <= MODE_OFF;
      phase_q       <= 4'd0;
      ticks_q       <= T200;
      lit_q         <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        active_high_q <= cfg_data_i;
      end
      if (s_fire) begin
        mode_q  <= mode_d;
        phase_q <= phase_d;
        ticks_q <= ticks_d;
        lit_q   <= lit_d;
      end
      if (s_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      m_pin_q  <= ~(lit_d ^ active_high_q);
      m_step_q <= step_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_pin_q};
  assign m_axis_tuser  = m_step_q;

  `SLBS_ASSERT_NEXT(a_mode_beat_no_step, s_fire && s_axis_tuser == ACT_MODE, !m_axis_tuser && $stable(ticks_q))
  `SLBS_ASSERT_NEXT(a_tick_counts_down, s_fire && s_axis_tuser == ACT_TICK && ticks_q > TicksWidth'(1), !m_axis_tuser && ticks_q == $past(ticks_q) - TicksWidth'(1))
  `SLBS_ASSERT_NEXT(a_expiry_reloads, s_fire && s_axis_tuser == ACT_TICK && ticks_q <= TicksWidth'(1), m_axis_tuser && ticks_q != '0)

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for status_led_blink_sequencer: drives tick and mode beats,
// predicts pin level and step flag per beat, and compares every result beat.
// Depends on slbs_pkg and the RTL of the block.
module tb;
  import slbs_pkg::*;

  localparam int unsigned TICKS_PER_MS = TicksPerMsDef;
  localparam int unsigned COUNT_CEIL   = 2047;
  localparam int unsigned WRAP_MS      = 100;
  localparam int unsigned STEADY_MS    = 1000;
  localparam int unsigned FIRST_MS     = 200;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic pin;
    logic step;
  } led_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [2:0] mode, [7:3] zero
  logic       s_axis_tuser;   // [0] action
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [0] pin_level, [7:1] zero
  logic       m_axis_tuser;   // [0] step_taken
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_data_i;

  // Mirror of the sequencer state.
  logic [2:0]  led_mode;
  logic [3:0]  led_phase;
  logic [10:0] led_countdown;
  logic        led_on;
  logic        pin_polarity;

  led_result_t led_results_due[$];
  led_result_t want;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned rx_hold_cycles;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned steps_run;
  int unsigned wraps_run;
  int unsigned mode_switches;
  int unsigned polarity_writes;
  int unsigned quiet_cycles;

  status_led_blink_sequencer #(
    .TICKS_PER_MS(TICKS_PER_MS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic [10:0] period_to_ticks(input int unsigned ms);
    longint unsigned t;
    t = longint'(ms) * longint'(TICKS_PER_MS);
    if (t > COUNT_CEIL) begin
      t = COUNT_CEIL;
    end
    return t[10:0];
  endfunction

  function automatic logic [3:0] blink_length(input logic [2:0] md);
    case (md)
      MODE_WIFI:  return 4'd2;
      MODE_MQTT:  return 4'd4;
      MODE_SMART: return 4'd6;
      MODE_OTA:   return 4'd8;
      MODE_READY: return 4'd4;
      default:    return 4'd0;
    endcase
  endfunction

  function automatic int unsigned blink_period_ms(input logic [2:0] md, input logic [2:0] ph);
    case (md)
      MODE_WIFI:  return (ph == 3'd1) ? 1000 : 200;
      MODE_MQTT:  return (ph == 3'd3) ? 2000 : 400;
      MODE_SMART: return (ph == 3'd5) ? 1000 : 200;
      MODE_OTA:   return (ph == 3'd7) ? 1000 : 200;
      MODE_READY: begin
        if (ph == 3'd1) begin
          return 75;
        end else if (ph == 3'd3) begin
          return 1000;
        end
        return 150;
      end
      default:    return 0;
    endcase
  endfunction

  // Applies one accepted beat to the mirrored state and gives the result it must produce.
  task automatic step_led_sequence(input logic act, input logic [2:0] md,
                                   output led_result_t res);
    int unsigned ms;
    logic [3:0]  ph;
    res.step = 1'b0;
    if (act == ACT_MODE) begin
      if (md != led_mode) begin
        led_mode  = md;
        led_phase = 4'd0;
        mode_switches++;
      end
    end else if (led_countdown > 11'd1) begin
      led_countdown = led_countdown - 11'd1;
    end else begin
      res.step = 1'b1;
      steps_run++;
      ph = led_phase;
      if (led_mode == MODE_OFF) begin
        led_on = 1'b0;
        ms = STEADY_MS;
      end else if (led_mode == MODE_ERROR) begin
        led_on = 1'b1;
        ms = STEADY_MS;
      end else if (led_mode == MODE_STARTUP) begin
        led_on    = ~ph[0];
        led_phase = ph + 4'd1;
        ms = FIRST_MS;
      end else if (ph < blink_length(led_mode)) begin
        led_on    = ~ph[0];
        ms        = blink_period_ms(led_mode, ph[2:0]);
        led_phase = ph + 4'd1;
      end else begin
        led_phase = 4'd0;
        ms = WRAP_MS;
        wraps_run++;
      end
      led_countdown = period_to_ticks(ms);
    end
    res.pin = pin_polarity ? led_on : ~led_on;
  endtask

  task automatic send_beat(input logic act, input logic [2:0] md);
    led_result_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
        @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'd0, md};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    step_led_sequence(act, md, res);
    led_results_due.push_back(res);
    beats_sent++;
  endtask

  task automatic set_mode(input logic [2:0] md);
    send_beat(ACT_MODE, md);
  endtask

  // Sends ticks, with random bits in the unused mode field, until n pattern steps have run.
  task automatic tick_until_step(input int unsigned n);
    int unsigned target;
    target = steps_run + n;
    while (steps_run < target) begin
      send_beat(ACT_TICK, 3'($urandom_range(7)));
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (led_results_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_polarity(input logic v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    pin_polarity = v;
    polarity_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    set_mode(MODE_OFF);
    send_beat(ACT_TICK, 3'd7);
    send_beat(ACT_TICK, 3'd0);
    set_mode(MODE_READY);
    tick_until_step(1);
  endtask

  // Runs the short ready phases, then repeats the mode and switches away to clear the phase.
  task automatic test_pattern_walk();
    tick_until_step(2);
    set_mode(MODE_READY);
    set_mode(MODE_WIFI);
    set_mode(MODE_STARTUP);
  endtask

  task automatic test_polarity();
    drain_results();
    write_polarity(1'b0);
    tick_until_step(2);
    drain_results();
    write_polarity(1'b1);
    send_beat(ACT_TICK, 3'd5);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_results();
    @(posedge clk_i);
    rx_hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) begin
      if (i % 8 == 3) begin
        set_mode(3'($urandom_range(7)));
      end else begin
        send_beat(ACT_TICK, 3'($urandom_range(7)));
      end
    end
    drain_results();
  endtask

  // Sends about n beats: mode changes, repeated modes and short tick bursts.
  task automatic test_random(input int unsigned n, input int unsigned tx_pct,
                             input int unsigned rx_pct);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = beats_sent + n;
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        set_mode(3'($urandom_range(7)));
      end else if (pick < 25) begin
        set_mode(led_mode);
      end else begin
        repeat ($urandom_range(8, 1)) send_beat(ACT_TICK, 3'($urandom_range(7)));
      end
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (led_results_due.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected result beat %0d: pin %b step %b", results_seen,
                   m_axis_tdata[0], m_axis_tuser);
        end
        mismatches++;
      end else begin
        want = led_results_due.pop_front();
        if (m_axis_tdata[0] !== want.pin || m_axis_tuser !== want.step) begin
          if (mismatches < 10) begin
            $display("Result beat %0d: expected pin %b step %b, got pin %b step %b",
                     results_seen, want.pin, want.step, m_axis_tdata[0], m_axis_tuser);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'd0;
    s_axis_tuser   = ACT_TICK;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = 1'b1;
    send_idle_pct  = 30;
    recv_idle_pct  = 67;
    rx_hold_cycles = 0;
    beats_sent      = 0;
    results_seen    = 0;
    mismatches      = 0;
    steps_run       = 0;
    wraps_run       = 0;
    mode_switches   = 0;
    polarity_writes = 0;
    led_mode      = MODE_OFF;
    led_phase     = 4'd0;
    led_countdown = period_to_ticks(FIRST_MS);
    led_on        = 1'b0;
    pin_polarity  = 1'b1;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_polarity(1'b1);
    test_reset_defaults();
    test_pattern_walk();
    test_polarity();
    test_backpressure();

    drain_results();
    write_polarity(1'b0);
    test_random(76, 30, 67);
    drain_results();
    write_polarity(1'b1);
    test_random(76, 67, 30);
    drain_results();
    write_polarity(1'($urandom_range(1)));
    test_random(76, 0, 0);

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d beats with %0d mode switches, %0d pattern steps and %0d wraps,",
             beats_sent, mode_switches, steps_run, wraps_run);
    $display("over %0d polarity writes, one long output stall and three idling mixes.",
             polarity_writes);
    if (led_results_due.size() != 0) begin
      $display("%0d result beats never arrived", led_results_due.size());
    end
    if (mismatches == 0 && led_results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- status_led_blink_sequencer.f -----
+incdir+rtl
rtl/slbs_pkg.sv
rtl/status_led_blink_sequencer.sv
sim/tb.sv
